@@ sv/i2cm_pkg.sv @@
package i2cm_pkg;

  // Command kinds
  localparam logic [2:0] K_START = 3'd0;
  localparam logic [2:0] K_STOP  = 3'd1;
  localparam logic [2:0] K_WRITE = 3'd2;
  localparam logic [2:0] K_READ  = 3'd3;
  localparam logic [2:0] K_ADDR  = 3'd4;

  // Segment counts per command
  localparam logic [4:0] SEGS_START = 5'd4;
  localparam logic [4:0] SEGS_STOP  = 5'd3;
  localparam logic [4:0] SEGS_BYTE  = 5'd18;

  // First segment of the ack slot in a byte command
  localparam logic [4:0] SEG_ACK = 5'd16;

  localparam int unsigned TIMER_WIDTH_DEF = 16;
  localparam logic [15:0] HALF_PERIOD_RST = 16'd250;

  typedef struct packed {
    logic       cmd_valid;
    logic [2:0] kind;
    logic [7:0] tx_byte;
    logic       read_not_write;
    logic       send_ack;
    logic       sda_in;
  } i2cm_cmd_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       busy_res;
    logic       done_res;
    logic [7:0] rx_byte;
    logic       ack_received;
  } i2cm_res_t;

  // Number of half-bit segments a command runs
  function automatic logic [4:0] seg_total(input logic [2:0] kind);
    logic [4:0] n;
    case (kind)
      K_START: n = SEGS_START;
      K_STOP:  n = SEGS_STOP;
      default: n = SEGS_BYTE;
    endcase
    return n;
  endfunction

endpackage

@@ sv/i2cm_if.sv @@
interface i2cm_in_if;
  logic       valid;
  logic       ready;
  logic       cmd_valid;
  logic [2:0] kind;
  logic [7:0] tx_byte;
  logic       read_not_write;
  logic       send_ack;
  logic       sda_in;

  modport source (output valid, cmd_valid, kind, tx_byte, read_not_write, send_ack, sda_in,
                  input ready);
  modport sink (input valid, cmd_valid, kind, tx_byte, read_not_write, send_ack, sda_in,
                output ready);
endinterface

interface i2cm_out_if;
  logic       valid;
  logic       ready;
  logic       scl_drive_low;
  logic       sda_drive_low;
  logic       busy_res;
  logic       done_res;
  logic [7:0] rx_byte;
  logic       ack_received;

  modport source (output valid, scl_drive_low, sda_drive_low, busy_res, done_res, rx_byte,
                  ack_received, input ready);
  modport sink (input valid, scl_drive_low, sda_drive_low, busy_res, done_res, rx_byte,
                ack_received, output ready);
endinterface

interface i2cm_cfg_if;
  logic        valid;
  logic        ready;
  logic [15:0] data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

@@ sv/i2cm_core.sv @@
module i2cm_core #(
  parameter int unsigned TIMER_WIDTH = i2cm_pkg::TIMER_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  i2cm_pkg::i2cm_cmd_t  cmd,
  input  logic [15:0]          half_period,
  output i2cm_pkg::i2cm_res_t  res
);

  logic [4:0]             phase_r, phase_nxt;
  logic [3:0]             bit_count_r, bit_count_nxt;
  logic [TIMER_WIDTH-1:0] timer_r, timer_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [2:0]             kind_r, kind_nxt;
  logic                   ack_choice_r, ack_choice_nxt;
  logic                   scl_r, scl_nxt;
  logic                   sda_r, sda_nxt;
  logic                   ack_flag_r, ack_flag_nxt;
  logic [7:0]             rx_r, rx_nxt;
  logic                   done;
  logic [15:0]            half_m1;
  logic [TIMER_WIDTH-1:0] timer_load;
  logic [4:0]             seg;
  logic [7:0]             shift_init;
  logic [1:0]             drv;

  // Line drives at the start of segment s, as {scl, sda}
  function automatic logic [1:0] enter_seg(input logic [2:0] kind, input logic [4:0] s,
                                           input logic [3:0] bc, input logic [7:0] sh,
                                           input logic ackc, input logic scl,
                                           input logic sda);
    logic c;
    logic d;
    c = scl;
    d = sda;
    case (kind)
      i2cm_pkg::K_START: begin
        case (s)
          5'd0:    c = 1'b1;
          5'd1:    d = 1'b0;
          5'd2:    c = 1'b0;
          default: d = 1'b1;
        endcase
      end
      i2cm_pkg::K_STOP: begin
        case (s)
          5'd0: begin
            c = 1'b1;
            d = 1'b1;
          end
          5'd1:    c = 1'b0;
          default: d = 1'b0;
        endcase
      end
      i2cm_pkg::K_READ: begin
        if (s[0]) begin
          c = 1'b0;
        end else begin
          c = 1'b1;
          if (s == 5'd0) d = 1'b0;
          else if (s == i2cm_pkg::SEG_ACK) d = ackc;
        end
      end
      default: begin
        if (s[0]) begin
          c = 1'b0;
        end else begin
          c = 1'b1;
          if (s < i2cm_pkg::SEG_ACK) d = ~sh[3'(3'd7 - bc[2:0])];
          else d = 1'b0;
        end
      end
    endcase
    return {c, d};
  endfunction

  // Segment length minus one, zero period treated as one
  assign half_m1    = (half_period == 16'd0) ? 16'd0 : half_period - 16'd1;
  assign timer_load = TIMER_WIDTH'(half_m1);

  // Advance the sequencer by one tick
  always_comb begin
    phase_nxt      = phase_r;
    bit_count_nxt  = bit_count_r;
    timer_nxt      = timer_r;
    shift_nxt      = shift_r;
    kind_nxt       = kind_r;
    ack_choice_nxt = ack_choice_r;
    scl_nxt        = scl_r;
    sda_nxt        = sda_r;
    ack_flag_nxt   = ack_flag_r;
    rx_nxt         = rx_r;
    done           = 1'b0;
    seg            = phase_r - 5'd1;
    drv            = {scl_r, sda_r};
    if (cmd.kind == i2cm_pkg::K_ADDR) shift_init = {cmd.tx_byte[7:1], cmd.read_not_write};
    else if (cmd.kind == i2cm_pkg::K_READ) shift_init = 8'd0;
    else shift_init = cmd.tx_byte;

    if (step) begin
      if (phase_r == 5'd0) begin
        // Launch a new command from idle
        if (cmd.cmd_valid && cmd.kind <= i2cm_pkg::K_ADDR) begin
          kind_nxt       = cmd.kind;
          bit_count_nxt  = 4'd0;
          shift_nxt      = shift_init;
          ack_choice_nxt = cmd.send_ack;
          phase_nxt      = 5'd1;
          drv            = enter_seg(cmd.kind, 5'd0, 4'd0, shift_init, cmd.send_ack,
                                     scl_r, sda_r);
          scl_nxt        = drv[1];
          sda_nxt        = drv[0];
          timer_nxt      = timer_load;
        end
      end else if (timer_r != '0) begin
        timer_nxt = timer_r - TIMER_WIDTH'(1);
      end else begin
        // Close the current segment: sample SDA at the end of SCL high
        if ((kind_r == i2cm_pkg::K_READ || kind_r == i2cm_pkg::K_WRITE ||
             kind_r == i2cm_pkg::K_ADDR) && seg[0]) begin
          if (seg < i2cm_pkg::SEG_ACK) begin
            if (kind_r == i2cm_pkg::K_READ) shift_nxt = {shift_r[6:0], cmd.sda_in};
            bit_count_nxt = bit_count_r + 4'd1;
          end else if (kind_r != i2cm_pkg::K_READ) begin
            ack_flag_nxt = ~cmd.sda_in;
          end
        end
        if (phase_r >= i2cm_pkg::seg_total(kind_r)) begin
          phase_nxt = 5'd0;
          done      = 1'b1;
          if (kind_r == i2cm_pkg::K_READ) rx_nxt = shift_nxt;
        end else begin
          phase_nxt = phase_r + 5'd1;
          drv       = enter_seg(kind_r, phase_r, bit_count_nxt, shift_nxt, ack_choice_r,
                                scl_r, sda_r);
          scl_nxt   = drv[1];
          sda_nxt   = drv[0];
          timer_nxt = timer_load;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= 5'd0;
      bit_count_r  <= 4'd0;
      timer_r      <= '0;
      shift_r      <= 8'd0;
      kind_r       <= 3'd0;
      ack_choice_r <= 1'b0;
      scl_r        <= 1'b0;
      sda_r        <= 1'b0;
      ack_flag_r   <= 1'b0;
      rx_r         <= 8'd0;
    end else begin
      phase_r      <= phase_nxt;
      bit_count_r  <= bit_count_nxt;
      timer_r      <= timer_nxt;
      shift_r      <= shift_nxt;
      kind_r       <= kind_nxt;
      ack_choice_r <= ack_choice_nxt;
      scl_r        <= scl_nxt;
      sda_r        <= sda_nxt;
      ack_flag_r   <= ack_flag_nxt;
      rx_r         <= rx_nxt;
    end
  end

  // Report the state after this tick
  always_comb begin
    res.scl_drive_low = scl_nxt;
    res.sda_drive_low = sda_nxt;
    res.busy_res      = (phase_nxt != 5'd0);
    res.done_res      = done;
    res.rx_byte       = rx_nxt;
    res.ack_received  = ack_flag_nxt;
  end

endmodule

@@ sv/i2c_bit_level_master_top.sv @@
// I2C bit-level master sequencer.
// in_ch carries one timer tick per transfer: an optional command (start, stop,
// write byte, read byte, address byte) and the sampled SDA level. Each command
// runs as a list of half-bit segments of half_period_ticks ticks each.
// out_ch returns exactly one result per input tick: SCL/SDA pull-down drives,
// busy and done flags, the last read byte and the last slave acknowledge.
// cfg_ch writes half_period_ticks; write it only while no command runs and
// all results have been taken.
// The result of a tick appears in the cycle after its input transfer, held in
// the output register. One tick per cycle while out_ch does not stall; the
// sequencer state update is a single pass from the state registers to the
// output register. The input is accepted while the output register is empty
// or is being drained in the same cycle, so a stall on out_ch backs up to
// in_ch without losing or repeating a result.
// Reset (synchronous, active low): idle, both lines released, flags cleared,
// half period back to 250 ticks.
module i2c_bit_level_master_top #(
  parameter int unsigned TIMER_WIDTH = i2cm_pkg::TIMER_WIDTH_DEF
) (
  input logic        clk,
  input logic        rst_n,
  i2cm_in_if.sink    in_ch,
  i2cm_out_if.source out_ch,
  i2cm_cfg_if.sink   cfg_ch
);

  logic                 out_valid_r;
  i2cm_pkg::i2cm_res_t  out_res_r;
  i2cm_pkg::i2cm_res_t  core_res;
  i2cm_pkg::i2cm_cmd_t  cmd;
  logic [15:0]          half_r;
  logic                 in_xfer;

  // Configuration register, always ready
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      half_r <= i2cm_pkg::HALF_PERIOD_RST;
    end else if (cfg_ch.valid) begin
      half_r <= cfg_ch.data;
    end
  end

  // Accept while the output slot is free or draining
  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_xfer     = in_ch.valid && in_ch.ready;

  always_comb begin
    cmd.cmd_valid      = in_ch.cmd_valid;
    cmd.kind           = in_ch.kind;
    cmd.tx_byte        = in_ch.tx_byte;
    cmd.read_not_write = in_ch.read_not_write;
    cmd.send_ack       = in_ch.send_ack;
    cmd.sda_in         = in_ch.sda_in;
  end

  i2cm_core #(
    .TIMER_WIDTH (TIMER_WIDTH)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (in_xfer),
    .cmd         (cmd),
    .half_period (half_r),
    .res         (core_res)
  );

  // Output register: load on input transfer, drop once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) out_res_r <= core_res;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.scl_drive_low = out_res_r.scl_drive_low;
  assign out_ch.sda_drive_low = out_res_r.sda_drive_low;
  assign out_ch.busy_res      = out_res_r.busy_res;
  assign out_ch.done_res      = out_res_r.done_res;
  assign out_ch.rx_byte       = out_res_r.rx_byte;
  assign out_ch.ack_received  = out_res_r.ack_received;

endmodule

@@ sv/i2cm_checker.sv @@
module i2cm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_busy,
  input logic out_done
);

  // A finished command never reports busy on the same tick
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done |-> !out_busy)
    else $error("done and busy reported together");

  // Every input transfer yields a result in the next cycle
  a_in_gives_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("input transfer without result");

  // A drained result with no new input empties the output
  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !(in_valid && in_ready) |=> !out_valid)
    else $error("result repeated");

  // Stalled result stays offered
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped under stall");

endmodule

bind i2c_bit_level_master_top i2cm_checker u_i2cm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_busy  (out_ch.busy_res),
  .out_done  (out_ch.done_res)
);
